FILE: hw/rtl/rnta_pkg.sv
// Shared types, constants and control structs for the radix number to ASCII unit.
package rnta_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int CHAR_W              = 7;
    localparam int DIGIT_W             = 4;
    localparam int RADIX_W             = 5;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] ERROR_CHAR = 7'd0;

    // Lower-case ASCII for each digit value.
    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic [31:0]        value;
        logic [RADIX_W-1:0] radix;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              error;
    } digit_t;

    typedef struct packed {
        logic start;
        logic div_start;
        logic div_step;
        logic push;
        logic pop;
        logic out_digit;
        logic out_error;
    } cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic step_last;
        logic quot_zero;
        logic count_zero;
    } status_t;

endpackage

FILE: hw/rtl/radix_number_to_ascii_unit.sv
// Radix conversion unit: an unsigned value and a radix in, one ASCII digit
// per outgoing transaction, most significant digit first, with last marking
// the final digit. A radix outside 2 to 16 gives a single transaction with
// error and last set and a zero character. The quotient is produced by one
// shared bit-serial divider at one quotient bit per cycle; each remainder is
// pushed on the digit stack and the digits are popped from it in reverse order.
// Only the low VALUE_WIDTH bits of value are converted. One item is worked on
// at a time; the next is taken once its final digit sits in the output register.
module radix_number_to_ascii_unit
    import rnta_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    output logic   digit_valid,
    input  logic   digit_stall,
    output digit_t digit
);

    cmd_t    cmd;
    status_t status;

    rnta_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .status      (status),
        .cmd         (cmd)
    );

    rnta_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .digit  (digit)
    );

endmodule

FILE: hw/rtl/rnta_ctrl.sv
// Sequencing state machine for the radix conversion: divide, stack and emit phases.
module rnta_ctrl
    import rnta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    output logic    digit_valid,
    input  logic    digit_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_POP,
        ST_EMIT,
        ST_ERR
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign item_stall  = (state_reg != ST_IDLE);
    assign digit_valid = out_valid_reg;

    // The output register may be reloaded once its transaction completes.
    assign out_free = !out_valid_reg || !digit_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && digit_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (status.radix_ok)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (status.quot_zero)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_digit  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = status.count_zero ? ST_IDLE : ST_POP;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    cmd.out_error  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/rnta_datapath.sv
// Bit-serial divider, digit stack memory and output register of the radix conversion.
module rnta_datapath
    import rnta_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  cmd_t    cmd,
    output status_t status,
    output digit_t  digit
);

    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [DIGIT_W-1:0]     stack_mem [VALUE_WIDTH];

    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [AW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          count_dec;
    logic [DIGIT_W-1:0]     rd_data_reg;
    digit_t                 out_reg;

    logic [RADIX_W-1:0]     rem_sh;
    logic [RADIX_W-1:0]     rem_diff;
    logic                   rem_ge;

    // One restoring-division step: bring down the next dividend bit.
    assign rem_sh    = {rem_reg, div_reg[VALUE_WIDTH-1]};
    assign rem_ge    = (rem_sh >= radix_reg);
    assign rem_diff  = rem_sh - radix_reg;
    assign count_dec = count_reg - 1'b1;

    assign status.radix_ok   = (item.radix >= RADIX_MIN) && (item.radix <= RADIX_MAX);
    assign status.step_last  = (bit_cnt_reg == AW'(VALUE_WIDTH - 1));
    assign status.quot_zero  = (div_reg == '0);
    assign status.count_zero = (count_reg == '0);

    assign digit = out_reg;

    always_comb
    begin
        div_next     = div_reg;
        rem_next     = rem_reg;
        radix_next   = radix_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;

        if (cmd.start)
        begin
            div_next     = VALUE_WIDTH'(item.value);
            radix_next   = item.radix;
            rem_next     = '0;
            bit_cnt_next = '0;
            count_next   = '0;
        end
        if (cmd.div_step)
        begin
            div_next     = {div_reg[VALUE_WIDTH-2:0], rem_ge};
            rem_next     = rem_ge ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            rem_next     = '0;
            bit_cnt_next = '0;
        end
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    // Digit stack: pushed at the count, popped one below it.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[count_reg[AW-1:0]] <= rem_reg;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= stack_mem[count_dec[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_digit)
        begin
            out_reg.digit_char <= DIGIT_CHARS[rd_data_reg];
            out_reg.last       <= status.count_zero;
            out_reg.error      <= 1'b0;
        end
        else if (cmd.out_error)
        begin
            out_reg.digit_char <= ERROR_CHAR;
            out_reg.last       <= 1'b1;
            out_reg.error      <= 1'b1;
        end
    end

endmodule

FILE: hw/rtl/rnta_checker.sv
// Port-level assertions for the radix conversion unit and their binding.
module rnta_checker
    import rnta_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   item_valid,
    input logic   item_stall,
    input item_t  item,
    input logic   digit_valid,
    input logic   digit_stall,
    input digit_t digit
);

    // A stalled result must be held unchanged.
    a_digit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_stall |=> digit_valid && $stable(digit))
        else $error("result changed while stalled");

    // An error result closes its conversion and carries no character.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit.error |-> digit.last && (digit.digit_char == ERROR_CHAR))
        else $error("malformed error result");

    // A good result carries a lower-case hexadecimal character.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit.error |->
            ((digit.digit_char >= 7'h30) && (digit.digit_char <= 7'h39)) ||
            ((digit.digit_char >= 7'h61) && (digit.digit_char <= 7'h66)))
        else $error("result character out of range");

    // After taking a transaction the unit stalls its input in the following cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken twice in a row");

endmodule

bind radix_number_to_ascii_unit rnta_checker u_rnta_checker (.*);

FILE: sim/tb_radix_number_to_ascii_unit.sv
// Self-checking testbench for the radix number to ASCII conversion unit.
`timescale 1ns / 1ps

module tb_radix_number_to_ascii_unit;
    import rnta_pkg::*;

    localparam int RANDOM_ITEMS = 106;
    localparam int DRAIN_CYCLES = 200;

    class digit_scoreboard;
        digit_t expected_digits[$];
        int     errors = 0;

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        // Converts one accepted value into its expected digit transactions.
        function void note_item(input item_t it);
            logic [3:0]  remainders[$];
            logic [31:0] base;
            logic [31:0] rest;
            logic [3:0]  d;
            digit_t      exp_digit;
            if (it.radix < RADIX_MIN || it.radix > RADIX_MAX)
            begin
                exp_digit.digit_char = ERROR_CHAR;
                exp_digit.last       = 1'b1;
                exp_digit.error      = 1'b1;
                expected_digits.push_back(exp_digit);
            end
            else
            begin
                base = 32'(it.radix);
                rest = it.value;
                do
                begin
                    remainders.push_back(4'(rest % base));
                    rest = rest / base;
                end
                while (rest != 0);
                // The remainders come out least significant first, so unwind them.
                while (remainders.size() > 0)
                begin
                    d = remainders.pop_back();
                    exp_digit.digit_char = (d < 4'd10) ? 7'h30 + 7'(d) : 7'h57 + 7'(d);
                    exp_digit.last       = (remainders.size() == 0);
                    exp_digit.error      = 1'b0;
                    expected_digits.push_back(exp_digit);
                end
            end
        endfunction

        task check_digit(input digit_t got);
            digit_t exp_digit;
            if (expected_digits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digit transaction char=%h last=%b error=%b",
                                          got.digit_char, got.last, got.error));
            end
            else
            begin
                exp_digit = expected_digits.pop_front();
                if (got.digit_char !== exp_digit.digit_char)
                    report_mismatch($sformatf("digit_char %h, expected %h",
                                              got.digit_char, exp_digit.digit_char));
                if (got.last !== exp_digit.last)
                    report_mismatch($sformatf("last %b, expected %b", got.last, exp_digit.last));
                if (got.error !== exp_digit.error)
                    report_mismatch($sformatf("error %b, expected %b",
                                              got.error, exp_digit.error));
            end
        endtask
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   item_valid = 1'b0;
    logic   item_stall;
    item_t  item = '0;
    logic   digit_valid;
    logic   digit_stall = 1'b0;
    digit_t digit;

    bit gaps_on = 1'b1;

    digit_scoreboard sb;

    radix_number_to_ascii_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        digit_stall <= gaps_on && ($urandom_range(99) < 23);
    end

    always @(posedge clk)
    begin
        if (rst_n && digit_valid && !digit_stall)
            sb.check_digit(digit);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [31:0] value, input logic [RADIX_W-1:0] radix);
        item_t it;
        it.value = value;
        it.radix = radix;
        while (gaps_on && ($urandom_range(99) < 23))
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(255);
            2: return (32'h1 << $urandom_range(31)) - $urandom_range(1);
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        int r;
        if ($urandom_range(99) < 85)
            return RADIX_W'($urandom_range(16, 2));
        // Out-of-range bases: 0, 1 and 17 to 31.
        r = $urandom_range(16);
        return RADIX_W'((r < 2) ? r : r + 15);
    endfunction

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Largest value in every valid base, including 32 binary digits.
        for (int r = 2; r <= 16; r++)
            send_item(32'hFFFF_FFFF, RADIX_W'(r));
        send_item(32'h0, 5'd2);
        send_item(32'h0, 5'd16);
        send_item(32'h8000_0000, 5'd2);
        send_item(32'h1, 5'd16);
        send_item(32'd16, 5'd16);
        send_item(32'h1234_5678, 5'd0);
        send_item(32'hFFFF_FFFF, 5'd1);
        send_item(32'h0, 5'd17);
        send_item(32'hA5A5_5A5A, 5'd31);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 50 && n < 90);
            send_item(pick_value(), pick_radix());
        end
        gaps_on = 1'b1;
        item_valid <= 1'b0;

        while (sb.expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.expected_digits.size() != 0)
            sb.report_mismatch($sformatf("%0d digit transactions never arrived",
                                         sb.expected_digits.size()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
